@@ rtl/ufat_pkg.sv @@
// ----------------------------------------------------------------------------
// ufat_pkg: shared definitions for the Unix time to FAT timestamp converter
// Holds the microcode word layout, the control program and the calendar tables.
// ----------------------------------------------------------------------------
package ufat_pkg;

	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned PcWidth     = 4;
	localparam int unsigned RemWidth    = 17;

	// Division by a constant: the power-of-two factor of the divisor is dropped
	// by a part-select, and the odd part is divided by multiplying with
	// ceil(2^s / d) and dropping s bits. Each reciprocal is exact over the whole
	// range that can reach it: 32-bit counts for the day, seconds within a day
	// for the hour, and seconds within an hour for the minute.
	localparam logic [25:0] DayRecip  = 26'd50903317;  // ceil(2^35 / 675)
	localparam int unsigned DayShift  = 35;
	localparam logic [13:0] HourRecip = 14'd9321;      // ceil(2^21 / 225)
	localparam int unsigned HourShift = 21;
	localparam logic [10:0] MinRecip  = 11'd1093;      // ceil(2^14 / 15)
	localparam int unsigned MinShift  = 14;

	// Year offsets count from 1970; 1970 mod 4 is 2, so offset mod 4 == 2 is a leap year.
	localparam logic [1:0] LeapPhase   = 2'd2;
	// FAT years count from 1980, which is offset 10 from 1970.
	localparam logic [7:0] FatBaseOff  = 8'd10;
	localparam logic [3:0] LastMonth   = 4'd11;

	typedef logic [PcWidth-1:0] pc_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_DAY_QUOT,
		OP_DAY_REM,
		OP_HOUR_QUOT,
		OP_HOUR_REM,
		OP_MIN_QUOT,
		OP_MIN_REM,
		OP_YEAR,
		OP_MONTH,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_YEAR_MORE,
		COND_MONTH_MORE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_word_t;

	localparam pc_t PcIdle = PcWidth'(0);
	localparam pc_t PcLast = PcWidth'(9);

	// Control program. Next step is target when the condition holds, else pc + 1.
	function automatic ctrl_word_t ucode(input pc_t pc);
		ctrl_word_t w;
		w = '{op: OP_IDLE, cond: COND_NO_START, target: PcIdle};
		unique case (pc)
			4'd0: w = '{op: OP_IDLE,      cond: COND_NO_START,   target: 4'd0};
			4'd1: w = '{op: OP_DAY_QUOT,  cond: COND_NEVER,      target: PcIdle};
			4'd2: w = '{op: OP_DAY_REM,   cond: COND_NEVER,      target: PcIdle};
			4'd3: w = '{op: OP_HOUR_QUOT, cond: COND_NEVER,      target: PcIdle};
			4'd4: w = '{op: OP_HOUR_REM,  cond: COND_NEVER,      target: PcIdle};
			4'd5: w = '{op: OP_MIN_QUOT,  cond: COND_NEVER,      target: PcIdle};
			4'd6: w = '{op: OP_MIN_REM,   cond: COND_NEVER,      target: PcIdle};
			4'd7: w = '{op: OP_YEAR,      cond: COND_YEAR_MORE,  target: 4'd7};
			4'd8: w = '{op: OP_MONTH,     cond: COND_MONTH_MORE, target: 4'd8};
			4'd9: w = '{op: OP_DONE,      cond: COND_ALWAYS,     target: 4'd0};
			default: w = '{op: OP_IDLE, cond: COND_ALWAYS, target: PcIdle};
		endcase
		return w;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		len = 5'd31;
		case (month)
			4'd1:                    len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ rtl/unix_time_to_fat_timestamp_top.sv @@
// ----------------------------------------------------------------------------
// unix_time_to_fat_timestamp_top: Unix seconds to FAT date and time words
// A microcoded sequencer drives a small multiply-subtract datapath.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low; unix_seconds is
// sampled at that edge. When the program has run, done is high for exactly
// one cycle with dos_date and dos_time valid in that same cycle; the receiver
// cannot stall the block, so it must capture the result then. The outputs
// keep their value until the next result. The sequencer program has one step
// each for the quotient and the remainder of the three constant divisions (by
// 86400, 3600 and 60, each a multiply by a scaled reciprocal), the year loop
// (one iteration per elapsed year since 1970 plus a final check), the month
// loop (one iteration per full month plus a final check) and one packing
// step; done is registered from the packing step. busy stays high from the
// accept edge through the packing step and is low again in the cycle in which
// done is shown, so one request is in flight at a time. Every year divisible
// by four is treated as a leap year, and years up to 1980 give a year field
// of zero.
module unix_time_to_fat_timestamp_top
	import ufat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] unix_seconds,
	output logic        done,
	output logic [15:0] dos_date,
	output logic [15:0] dos_time
);

	// Sequencer state.
	pc_t        pc_q;
	pc_t        pc_next;
	ctrl_word_t cw;
	logic       cond_true;
	logic       done_q;

	// Datapath registers. num_q holds the request's second count; rem_q holds
	// the seconds left within the day and then within the hour.
	logic [31:0]          num_q;
	logic [RemWidth-1:0]  rem_q;
	logic [15:0]          days_q;
	logic [7:0]           year_q;
	logic [3:0]           month_q;
	logic [4:0]           hours_q;
	logic [5:0]           mins_q;
	logic [4:0]           half_q;
	logic [15:0]          date_q;
	logic [15:0]          time_q;

	// Quotients and remainders of the constant divisions.
	logic [15:0]          day_quot;
	logic [RemWidth-1:0]  day_rem;
	logic [4:0]           hour_quot;
	logic [RemWidth-1:0]  hour_rem;
	logic [5:0]           min_quot;
	logic [4:0]           half_sec;

	// Calendar step values.
	logic        leap;
	logic [8:0]  year_span;
	logic        year_more;
	logic [4:0]  mlen;
	logic        month_more;
	logic [6:0]  fat_year;

	assign cw = ucode(pc_q);

	// 86400 = 128 * 675, 3600 = 16 * 225 and 60 = 4 * 15: the low bits are
	// dropped first and the odd factor goes through the reciprocal.
	assign day_quot  = 16'((51'(num_q[31:7]) * 51'(DayRecip)) >> DayShift);
	assign day_rem   = RemWidth'(num_q - 32'(33'(days_q) * 33'(SecsPerDay)));
	assign hour_quot = 5'((27'(rem_q[16:4]) * 27'(HourRecip)) >> HourShift);
	assign hour_rem  = rem_q - RemWidth'(hours_q) * RemWidth'(SecsPerHour);
	assign min_quot  = 6'((21'(rem_q[11:2]) * 21'(MinRecip)) >> MinShift);
	assign half_sec  = 5'((rem_q[11:0] - 12'(mins_q) * 12'(SecsPerMin)) >> 1);

	assign leap       = (year_q[1:0] == LeapPhase);
	assign year_span  = leap ? 9'd366 : 9'd365;
	assign year_more  = (days_q >= 16'(year_span));
	assign mlen       = month_len(month_q, leap);
	assign month_more = (month_q != LastMonth) && (days_q >= 16'(mlen));

	// Years past 1980 count from 1980; the rest give zero.
	assign fat_year = (year_q > FatBaseOff) ? 7'(year_q - FatBaseOff) : 7'd0;

	always_comb begin
		case (cw.cond)
			COND_NEVER:      cond_true = 1'b0;
			COND_ALWAYS:     cond_true = 1'b1;
			COND_NO_START:   cond_true = !start;
			COND_YEAR_MORE:  cond_true = year_more;
			COND_MONTH_MORE: cond_true = month_more;
			default:         cond_true = 1'b0;
		endcase
		pc_next = cond_true ? cw.target : pc_t'(pc_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PcIdle;
			done_q <= 1'b0;
		end else begin
			pc_q   <= pc_next;
			done_q <= (cw.op == OP_DONE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_IDLE: begin
				if (start) begin
					num_q <= unix_seconds;
				end
			end
			OP_DAY_QUOT: begin
				days_q <= day_quot;
			end
			OP_DAY_REM: begin
				rem_q   <= day_rem;
				year_q  <= '0;
				month_q <= '0;
			end
			OP_HOUR_QUOT: begin
				hours_q <= hour_quot;
			end
			OP_HOUR_REM: begin
				rem_q <= hour_rem;
			end
			OP_MIN_QUOT: begin
				mins_q <= min_quot;
			end
			OP_MIN_REM: begin
				half_q <= half_sec;
			end
			OP_YEAR: begin
				if (year_more) begin
					days_q <= days_q - 16'(year_span);
					year_q <= year_q + 1'b1;
				end
			end
			OP_MONTH: begin
				if (month_more) begin
					days_q  <= days_q - 16'(mlen);
					month_q <= month_q + 1'b1;
				end
			end
			OP_DONE: begin
				date_q <= {fat_year, 4'(month_q + 1'b1), 5'(days_q[4:0] + 1'b1)};
				time_q <= {hours_q, mins_q, half_q};
			end
			default: begin
			end
		endcase
	end

	assign busy     = (pc_q != PcIdle);
	assign done     = done_q;
	assign dos_date = date_q;
	assign dos_time = time_q;

`ifndef SYNTH
	// An accepted request always starts the program.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start the sequencer");

	// A result only follows work in flight, and the block is free again after it.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result without a request in flight");

	// One result per request: strobes never come back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// The sequencer never leaves its program.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PcLast)
		else $error("step counter outside the program");

	// The month search stops at December.
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == OP_DONE) |-> (month_q <= LastMonth))
		else $error("month index out of range");
`endif

endmodule
